/* hw/rtl/crc8_frame_receiver_unit_defines.svh */
// Assertion macros shared by the frame receiver RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef CRC8_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define CRC8_FRAME_RECEIVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// prop must hold at every rising edge outside reset
`define CRC8FR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("crc8fr assertion failed");

// cond must never be true at a rising edge outside reset
`define CRC8FR_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("crc8fr forbidden condition seen");

`else

`define CRC8FR_ASSERT(lbl, clk, rst, prop)

`define CRC8FR_NEVER(lbl, clk, rst, cond)

`endif

`endif

/* hw/rtl/crc8fr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and the CRC-8 byte update for the frame receiver.
// No dependencies.
package crc8fr_pkg;

   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_TOP  = 8'h80;
   localparam logic [7:0] CRC_INIT = 8'h00;

   localparam logic [7:0] HEADER_RESET = 8'd170;
   localparam logic [7:0] FOOTER_RESET = 8'd85;

   // register indexes on the csr port
   localparam logic [7:0] CSR_HEADER_IDX = 8'd0;
   localparam logic [7:0] CSR_FOOTER_IDX = 8'd1;

   // frame_status codes
   localparam logic [1:0] STATUS_GOOD     = 2'd0;
   localparam logic [1:0] STATUS_FOOTER   = 2'd1;
   localparam logic [1:0] STATUS_CRC      = 2'd2;

   typedef enum logic [1:0] {
      RX_HUNT,
      RX_COLLECT,
      RX_DRAIN,
      RX_LOAD
   } crc8fr_state_type;

   // controls from the sequencer to the CRC unit
   typedef struct packed {
      logic       clear;
      logic       feed;
      logic       check;
      logic [7:0] data;
   } crc8fr_crc_ctl_type;

   // one byte through CRC-8, MSB first, no reflection
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* hw/rtl/crc8fr_store.sv */
`timescale 1ns / 1ps
// Frame byte store: one write port, one read port, registered read data.
// No dependencies.
module crc8fr_store #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/crc8fr_crc.sv */
`timescale 1ns / 1ps
// Running CRC-8 over the payload and the compare against the CRC byte.
// Depends on crc8fr_pkg.
module crc8fr_crc (
   input  logic                         clock,
   input  logic                         reset,
   input  crc8fr_pkg::crc8fr_crc_ctl_type ctl,
   output logic                         match
);

   logic [7:0] crc_ff;
   logic [7:0] crc_in;
   logic       match_ff;
   logic       match_in;

   always_comb begin
      crc_in   = crc_ff;
      match_in = match_ff;
      if (ctl.clear) begin
         crc_in = crc8fr_pkg::CRC_INIT;
      end else if (ctl.feed) begin
         crc_in = crc8fr_pkg::crc8_feed(crc_ff, ctl.data);
      end
      // CRC byte arrives after the last fed byte
      if (ctl.check) begin
         match_in = (crc_ff == ctl.data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= crc8fr_pkg::CRC_INIT;
         match_ff <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         match_ff <= match_in;
      end
   end

   assign match = match_ff;

endmodule

/* hw/rtl/crc8_frame_receiver_unit.sv */
`timescale 1ns / 1ps
// Header/footer frame receiver with CRC-8 check. Bytes come in one per req beat. While
// hunting, a byte equal to header_value opens a frame of FRAME_BYTES bytes: header,
// payload (its last byte is the CRC byte) and footer. Frame bytes after the header go
// into a synchronous store with one write and one read port while a running CRC-8
// (poly 0x07, init 0, MSB first) is kept over the payload less its CRC byte. On the
// footer beat the footer is checked first, then the CRC. A bad frame gives one rsp beat
// (status footer or CRC mismatch, byte 0, tlast high) and bumps the 32-bit wrapping
// error count; a good frame gives FRAME_BYTES-2 payload beats, CRC byte included, tlast
// on the final one. The footer beat is held off while an earlier result still waits in
// the output register. A good frame is then read back from the store one payload beat
// at a time (store read, then output register load); req_tready is low during that
// read-back. The store read port is only used during read-back, when no writes happen,
// so no forwarding is needed.
module crc8_frame_receiver_unit #(
   parameter int unsigned FRAME_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] payload_byte, [39:8] error_count
   output logic [1:0]  rsp_tuser,   // [1:0] frame_status
   output logic        rsp_tlast,   // last_of_frame
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);

`include "crc8_frame_receiver_unit_defines.svh"

   localparam int unsigned PW = $clog2(FRAME_BYTES);
   localparam logic [PW-1:0] LAST_POS = PW'(FRAME_BYTES - 1); // footer
   localparam logic [PW-1:0] CRC_POS  = PW'(FRAME_BYTES - 2); // CRC byte
   localparam logic [PW-1:0] FEED_END = PW'(FRAME_BYTES - 3); // last CRC-covered byte

   // config registers
   logic [7:0] header_ff, header_in;
   logic [7:0] footer_ff, footer_in;

   // sequencer
   crc8fr_pkg::crc8fr_state_type state_ff, state_in;
   logic [PW-1:0] pos_ff, pos_in;    // frame position, then read-back index
   logic [31:0]   bad_ff, bad_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [31:0] rsp_count_ff, rsp_count_in;

   // store and CRC unit
   logic                           wr_en;
   logic                           rd_en;
   logic [7:0]                     rd_data;
   crc8fr_pkg::crc8fr_crc_ctl_type crc_ctl;
   logic                           crc_match;

   logic req_beat;
   logic rsp_beat;

   assign csr_ready = 1'b1;
   assign req_beat  = req_tvalid && req_tready;
   assign rsp_beat  = rsp_tvalid && rsp_tready;

   // register writes; unknown indexes are dropped
   always_comb begin
      header_in = header_ff;
      footer_in = footer_ff;
      if (csr_valid) begin
         unique case (csr_index)
            crc8fr_pkg::CSR_HEADER_IDX: header_in = csr_data;
            crc8fr_pkg::CSR_FOOTER_IDX: footer_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      bad_in        = bad_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      req_tready    = 1'b0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      crc_ctl.clear = 1'b0;
      crc_ctl.feed  = 1'b0;
      crc_ctl.check = 1'b0;
      crc_ctl.data  = req_tdata;

      unique case (state_ff)
         crc8fr_pkg::RX_HUNT: begin
            req_tready = 1'b1;
            if (req_beat && (req_tdata == header_ff)) begin
               crc_ctl.clear = 1'b1;
               pos_in        = PW'(1);
               state_in      = crc8fr_pkg::RX_COLLECT;
            end
         end
         crc8fr_pkg::RX_COLLECT: begin
            // footer beat waits for a free output register
            req_tready = (pos_ff != LAST_POS) || !rsp_valid_ff;
            if (req_beat) begin
               wr_en         = 1'b1;
               crc_ctl.feed  = (pos_ff <= FEED_END);
               crc_ctl.check = (pos_ff == CRC_POS);
               pos_in        = pos_ff + PW'(1);
               if (pos_ff == LAST_POS) begin
                  pos_in   = PW'(1);
                  state_in = crc8fr_pkg::RX_HUNT;
                  if (req_tdata != footer_ff) begin
                     bad_in        = bad_ff + 32'd1;
                     rsp_valid_in  = 1'b1;
                     rsp_byte_in   = 8'h00;
                     rsp_status_in = crc8fr_pkg::STATUS_FOOTER;
                     rsp_last_in   = 1'b1;
                     rsp_count_in  = bad_ff + 32'd1;
                  end else if (!crc_match) begin
                     bad_in        = bad_ff + 32'd1;
                     rsp_valid_in  = 1'b1;
                     rsp_byte_in   = 8'h00;
                     rsp_status_in = crc8fr_pkg::STATUS_CRC;
                     rsp_last_in   = 1'b1;
                     rsp_count_in  = bad_ff + 32'd1;
                  end else begin
                     state_in = crc8fr_pkg::RX_DRAIN;
                  end
               end
            end
         end
         crc8fr_pkg::RX_DRAIN: begin
            // read the next payload byte once the output register frees up
            if (!rsp_valid_ff || rsp_tready) begin
               rd_en    = 1'b1;
               state_in = crc8fr_pkg::RX_LOAD;
            end
         end
         crc8fr_pkg::RX_LOAD: begin
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = rd_data;
            rsp_status_in = crc8fr_pkg::STATUS_GOOD;
            rsp_last_in   = (pos_ff == CRC_POS);
            rsp_count_in  = bad_ff;
            pos_in        = pos_ff + PW'(1);
            if (pos_ff == CRC_POS) begin
               state_in = crc8fr_pkg::RX_HUNT;
            end else begin
               state_in = crc8fr_pkg::RX_DRAIN;
            end
         end
         default: state_in = crc8fr_pkg::RX_HUNT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crc8fr_pkg::RX_HUNT;
         pos_ff       <= '0;
         bad_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         header_ff    <= crc8fr_pkg::HEADER_RESET;
         footer_ff    <= crc8fr_pkg::FOOTER_RESET;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
         header_ff    <= header_in;
         footer_ff    <= footer_in;
      end
   end

   // payload of the output register
   always_ff @(posedge clock) begin
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   crc8fr_store #(
      .DEPTH (FRAME_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   crc8fr_crc u_crc (
      .clock (clock),
      .reset (reset),
      .ctl   (crc_ctl),
      .match (crc_match)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // store read data is always consumed in the following cycle
   `CRC8FR_ASSERT(a_read_then_load, clock, reset, rd_en |=> (state_ff == crc8fr_pkg::RX_LOAD))
   // read data lands only in an empty output register
   `CRC8FR_NEVER(a_load_into_full, clock, reset,
      (state_ff == crc8fr_pkg::RX_LOAD) && rsp_valid_ff)
   // error beats carry a zero byte and close the frame
   `CRC8FR_ASSERT(a_error_beat_shape, clock, reset,
      (rsp_valid_ff && (rsp_status_ff != crc8fr_pkg::STATUS_GOOD)) |->
      (rsp_last_ff && (rsp_byte_ff == 8'h00)))
   // the error count moves only with a freshly loaded error beat
   `CRC8FR_ASSERT(a_count_with_error, clock, reset,
      (bad_ff != $past(bad_ff)) |->
      (rsp_valid_ff && (rsp_status_ff != crc8fr_pkg::STATUS_GOOD) && (rsp_count_ff == bad_ff)))

endmodule

/* sim/crc8_frame_receiver_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench for crc8_frame_receiver_unit: drives byte beats and CSR writes.
// A behavioural frame tracker predicts every rsp beat. Depends on crc8fr_pkg and the RTL.
module crc8_frame_receiver_unit_tb;

   localparam int FRAME_BYTES  = 16;
   localparam int CRC_SPAN     = FRAME_BYTES - 3;   // payload bytes covered by the CRC
   localparam int DRAIN_CYCLES = 24;                // headroom after the last expected beat
   localparam int STUCK_LIMIT  = 2000;              // cycles without any handshake
   localparam int REPORT_MAX   = 10;
   localparam logic [7:0] CSR_SPARE_IDX = crc8fr_pkg::CSR_FOOTER_IDX + 8'd1;

   typedef enum int {FR_GOOD, FR_BAD_FOOTER, FR_BAD_CRC, FR_BAD_BOTH} frame_kind_type;

   // one rsp beat as the block should present it
   typedef struct packed {
      logic [7:0]  payload;
      logic [1:0]  status;
      logic        last;
      logic [31:0] err_count;
   } frame_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // [7:0] payload_byte, [39:8] error_count
   logic [1:0]  rsp_tuser;            // [1:0] frame_status
   logic        rsp_tlast;            // last_of_frame
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index  = 8'h00;
   logic [7:0]  csr_data   = 8'h00;

   // tracker state: register copies and the frame being collected
   logic [7:0]  m_header = crc8fr_pkg::HEADER_RESET;
   logic [7:0]  m_footer = crc8fr_pkg::FOOTER_RESET;
   bit          m_hunting = 1'b1;
   int          m_pos = 0;
   logic [7:0]  m_store [FRAME_BYTES];
   logic [7:0]  m_crc = crc8fr_pkg::CRC_INIT;
   logic [31:0] m_bad = 32'd0;

   frame_beat_type awaited_beats[$];
   int          mismatch_count = 0;
   int          bytes_sent = 0;
   int          stuck_cycles = 0;
   int          stall_left = 0;
   bit          idle_on = 1'b1;

   crc8_frame_receiver_unit #(.FRAME_BYTES(FRAME_BYTES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // CRC-8, poly 0x07, MSB first, one byte at a time
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = ((c & crc8fr_pkg::CRC_TOP) != 8'h00) ? ((c << 1) ^ crc8fr_pkg::CRC_POLY)
                                                  : (c << 1);
      end
      return c;
   endfunction

   function automatic void await_beat(input logic [7:0] b, input logic [1:0] st,
                                      input logic lst);
      frame_beat_type beat;
      beat.payload   = b;
      beat.status    = st;
      beat.last      = lst;
      beat.err_count = m_bad;
      awaited_beats.push_back(beat);
   endfunction

   // Frame tracker: one accepted rx byte in, zero or more expected beats out.
   function automatic void track_rx_byte(input logic [7:0] b);
      if (m_hunting) begin
         if (b == m_header) begin
            m_store[0] = b;
            m_pos      = 1;
            m_crc      = crc8fr_pkg::CRC_INIT;
            m_hunting  = 1'b0;
         end
         return;
      end
      // a header value inside a frame is just another frame byte
      m_store[m_pos] = b;
      if (m_pos >= 1 && m_pos <= CRC_SPAN) m_crc = crc8_step(m_crc, b);
      m_pos++;
      if (m_pos == FRAME_BYTES) begin
         // footer is judged first, so a frame bad on both counts reports the footer
         if (m_store[FRAME_BYTES-1] != m_footer) begin
            m_bad++;
            await_beat(8'h00, crc8fr_pkg::STATUS_FOOTER, 1'b1);
         end else if (m_crc != m_store[FRAME_BYTES-2]) begin
            m_bad++;
            await_beat(8'h00, crc8fr_pkg::STATUS_CRC, 1'b1);
         end else begin
            for (int i = 1; i <= FRAME_BYTES - 2; i++)
               await_beat(m_store[i], crc8fr_pkg::STATUS_GOOD, i == FRAME_BYTES - 2);
         end
         m_hunting = 1'b1;
         m_pos     = 0;
      end
   endfunction

   // Byte source: optional idle burst, then hold the beat until taken.
   // tvalid stays high between back-to-back beats.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= b;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      track_rx_byte(b);
   endtask

   // one CSR beat; csr_valid is left high so writes can go back to back
   task automatic send_reg(input logic [7:0] idx, input logic [7:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == crc8fr_pkg::CSR_HEADER_IDX) m_header = val;
      else if (idx == crc8fr_pkg::CSR_FOOTER_IDX) m_footer = val;
   endtask

   task automatic program_regs(input logic [7:0] hdr, input logic [7:0] ftr,
                               input bit poke_spare);
      send_reg(crc8fr_pkg::CSR_HEADER_IDX, hdr);
      send_reg(crc8fr_pkg::CSR_FOOTER_IDX, ftr);
      if (poke_spare) send_reg(8'($urandom_range(CSR_SPARE_IDX, 255)), 8'($urandom));
      csr_valid <= 1'b0;
   endtask

   // pad out any half-collected frame so the tracker is back to hunting
   task automatic close_frame();
      while (!m_hunting) send_byte(8'($urandom));
   endtask

   // stop sending, let every expected beat arrive, then give the block time to settle
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (awaited_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 11))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return m_header;
         3:       return m_footer;
         default: return 8'($urandom);
      endcase
   endfunction

   // Full frame around a given payload: header, payload, CRC byte, footer,
   // with the CRC and/or footer spoilt as the kind asks.
   task automatic send_payload_frame(input logic [CRC_SPAN-1:0][7:0] payload,
                                     input frame_kind_type kind);
      logic [7:0] crc;
      logic [7:0] ftr;
      crc = crc8fr_pkg::CRC_INIT;
      for (int i = 0; i < CRC_SPAN; i++) crc = crc8_step(crc, payload[i]);
      ftr = m_footer;
      if (kind == FR_BAD_CRC || kind == FR_BAD_BOTH) crc ^= 8'($urandom_range(1, 255));
      if (kind == FR_BAD_FOOTER || kind == FR_BAD_BOTH) ftr ^= 8'($urandom_range(1, 255));
      send_byte(m_header);
      for (int i = 0; i < CRC_SPAN; i++) send_byte(payload[i]);
      send_byte(crc);
      send_byte(ftr);
   endtask

   task automatic send_random_frame(input frame_kind_type kind);
      logic [CRC_SPAN-1:0][7:0] payload;
      // now and then a frame starts while another is still open (broken sequence)
      if (!m_hunting && $urandom_range(0, 3) != 0) close_frame();
      for (int i = 0; i < CRC_SPAN; i++) payload[i] = pick_byte();
      send_payload_frame(payload, kind);
   endtask

   task automatic test_random_traffic(input int n_bytes);
      int stop_at;
      int burst;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: send_random_frame(FR_GOOD);
            5:             send_random_frame(FR_BAD_FOOTER);
            6:             send_random_frame(FR_BAD_CRC);
            7:             send_random_frame(FR_BAD_BOTH);
            8: begin
               // line noise
               burst = $urandom_range(1, 5);
               repeat (burst) send_byte(8'($urandom));
            end
            default: begin
               // truncated frame; whatever follows lands inside it
               send_byte(m_header);
               burst = $urandom_range(1, CRC_SPAN);
               repeat (burst) send_byte(pick_byte());
            end
         endcase
      end
   endtask

   // --- directed tests, reset register values ---

   // bytes that are not the header must be dropped while hunting
   task automatic test_hunt_noise();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(m_footer);
   endtask

   // good frame with extreme bytes and the header value inside the payload
   task automatic test_good_frame_extremes();
      logic [CRC_SPAN-1:0][7:0] payload;
      payload = {8'h3C, 8'hF0, 8'h0F, 8'hA5, 8'h5A, 8'hFE, 8'h7F,
                 8'h80, 8'h01, 8'h55, 8'hAA, 8'hFF, 8'h00};
      payload[2] = m_header;
      send_payload_frame(payload, FR_GOOD);
   endtask

   // footer and CRC both wrong: only the footer mismatch is reported
   task automatic test_both_checks_fail();
      send_random_frame(FR_BAD_BOTH);
   endtask

   // --- register phases ---

   task automatic test_low_header_high_footer();
      close_frame();
      settle_idle();
      program_regs(8'h00, 8'hFF, 1'b1);
      test_random_traffic(75);
   endtask

   task automatic test_high_header_low_footer();
      close_frame();
      settle_idle();
      program_regs(8'hFF, 8'h00, 1'b0);
      test_random_traffic(75);
   endtask

   // last part: random registers, no idling on either side
   task automatic test_random_regs_no_idle();
      close_frame();
      settle_idle();
      idle_on = 1'b0;
      program_regs(8'($urandom), 8'($urandom), 1'b1);
      test_random_traffic(75);
   endtask

   // rsp side back-pressure: random stall bursts while idling is on
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && !reset && $urandom_range(0, 6) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // every rsp beat is held against the oldest expectation
   always @(posedge clock) begin
      frame_beat_type seen;
      frame_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = {rsp_tdata[7:0], rsp_tuser, rsp_tlast, rsp_tdata[39:8]};
         if (awaited_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected rsp beat: byte %02h status %0d last %0b count %0d",
                        seen.payload, seen.status, seen.last, seen.err_count);
         end else begin
            want = awaited_beats.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("rsp mismatch: want %02h/%0d/%0b/%0d got %02h/%0d/%0b/%0d",
                           want.payload, want.status, want.last, want.err_count,
                           seen.payload, seen.status, seen.last, seen.err_count);
            end
         end
      end
   end

   // watchdog: too long without any beat on any channel ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_hunt_noise();
      test_good_frame_extremes();
      test_both_checks_fail();
      test_low_header_high_footer();
      test_high_header_low_footer();
      test_random_regs_no_idle();

      settle_idle();
      if (mismatch_count == 0 && awaited_beats.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
